@@ hdl/bfd_pkg.sv @@
// bfd_pkg: operation codes, status codes and sizing defaults for the byte
// queue with delete by value. No dependencies.
`timescale 1ns / 1ps

package bfd_pkg;

  // default queue depth in words
  localparam int DEFAULT_DEPTH = 16;

  // operation codes on func
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_FIND   = 2'd2;

  // status codes on status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // read_value returned by remove on an empty queue
  localparam logic [7:0] EMPTY_READ = 8'hFF;

endpackage

@@ hdl/byte_fifo_with_delete_by_value.sv @@
// Byte queue with append, remove head and find-and-delete by value.
// Depends on bfd_pkg for operation and status codes.
//
// A request is taken when start is high and busy is low; its result shows
// on the result ports for one cycle with done high and cannot be held off.
// Append, code 3 and any request on an empty queue finish without a walk:
// done is high in the cycle right after the request is taken. Remove
// fetches the head, sets up the first move, then moves each later word
// down. A find compares words to the key in order until one hits, sets up
// the first move and moves the words after the hit down; a find that
// misses compares every word and then finishes.
// These walks follow from the storage array, which has one read and one
// write port and which a small sequencer walks one word per cycle, first
// comparing words to the key, then moving each later word down one place
// to close the gap.
// occupancy and is_empty always show the count after the last request.
`timescale 1ns / 1ps

module byte_fifo_with_delete_by_value
  import bfd_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    func,
  input  logic [7:0]    value,
  output logic          busy,
  output logic          done,
  output logic [7:0]    read_value,
  output logic [1:0]    status,
  output logic          found,
  output logic          is_empty,
  output logic [CW-1:0] occupancy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_SHIFT_PRE,
    ST_SHIFT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [AW-1:0] ptr;
  logic [7:0]    key;
  logic [7:0]    rdata;
  logic [7:0]    mem [DEPTH];

  // pointer arithmetic one bit wider than the count
  logic [CW:0]   cnt_x;
  logic [CW:0]   ptr_p1;
  logic [CW:0]   ptr_p2;
  logic          full;

  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  assign cnt_x  = (CW + 1)'(count);
  assign ptr_p1 = (CW + 1)'(ptr) + (CW + 1)'(1);
  assign ptr_p2 = (CW + 1)'(ptr) + (CW + 1)'(2);
  assign full   = (count == CW'(DEPTH));

  assign busy      = (state != ST_IDLE);
  assign occupancy = count;
  assign is_empty  = (count == '0);

  // read address follows the sequencer one word ahead of use
  always_comb begin
    case (state)
      ST_SCAN:      rd_addr = ptr_p1[AW-1:0];
      ST_SHIFT_PRE: rd_addr = ptr_p1[AW-1:0];
      ST_SHIFT:     rd_addr = ptr_p2[AW-1:0];
      default:      rd_addr = '0;
    endcase
  end

  // write port: append at tail, or move a word down during gap closing
  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = rdata;
    case (state)
      ST_IDLE: begin
        if (start && func == FUNC_APPEND && !full) begin
          we    = 1'b1;
          waddr = count[AW-1:0];
          wdata = value;
        end
      end
      ST_SHIFT: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // storage array, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            key        <= value;
            ptr        <= '0;
            read_value <= '0;
            status     <= STAT_OK;
            found      <= 1'b0;
            case (func)
              FUNC_APPEND: begin
                done <= 1'b1;
                if (full) begin
                  status <= STAT_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              FUNC_REMOVE: begin
                if (count == '0) begin
                  read_value <= EMPTY_READ;
                  status     <= STAT_EMPTY;
                  done       <= 1'b1;
                end else begin
                  state <= ST_HEAD;
                end
              end
              FUNC_FIND: begin
                if (count == '0) begin
                  status <= STAT_EMPTY;
                  done   <= 1'b1;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        // head word arrives, then close the gap from the head
        ST_HEAD: begin
          read_value <= rdata;
          state      <= ST_SHIFT_PRE;
        end
        // compare one stored word per cycle against the key
        ST_SCAN: begin
          if (rdata == key) begin
            found <= 1'b1;
            state <= ST_SHIFT_PRE;
          end else if (ptr_p1 >= cnt_x) begin
            status <= STAT_EMPTY;
            done   <= 1'b1;
            state  <= ST_IDLE;
          end else begin
            ptr <= ptr_p1[AW-1:0];
          end
        end
        // set up the first move, or finish if the removed word was the last one
        ST_SHIFT_PRE: begin
          if (ptr_p1 >= cnt_x) begin
            count <= count - CW'(1);
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_SHIFT;
          end
        end
        // move word ptr+1 into ptr, next word already being read
        ST_SHIFT: begin
          if (ptr_p2 >= cnt_x) begin
            count <= count - CW'(1);
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            ptr <= ptr_p1[AW-1:0];
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/bfd_checker.sv @@
// bfd_checker: port-level checks on the byte queue, bound to the top level.
// Depends on bfd_pkg and byte_fifo_with_delete_by_value.
`timescale 1ns / 1ps

module bfd_checker
  import bfd_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input logic [1:0]    status,
  input logic          found,
  input logic          is_empty,
  input logic [CW-1:0] occupancy
);

  // an accepted word either finishes next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither finished nor busy");

  // a result is never shown while a word is still being worked on
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while busy");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    is_empty == (occupancy == '0))
    else $error("is_empty disagrees with occupancy");

  // full refusal only with a full queue, whose count then equals depth
  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> (occupancy == CW'(DEPTH)))
    else $error("full status with room left");

  // a found match always reports success and leaves the count below depth
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == STAT_OK && occupancy < CW'(DEPTH)))
    else $error("found with bad status or count");

endmodule

bind byte_fifo_with_delete_by_value bfd_checker #(
  .DEPTH(DEPTH)
) u_bfd_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .status(status),
  .found(found),
  .is_empty(is_empty),
  .occupancy(occupancy)
);
